>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the clocked concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ieba_pkg.sv
// ----------------------------------------------------------------------------
// ieba_pkg
// Types and constants shared by the interrupt entry buffer allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ieba_pkg;

  localparam int BUFFER_SIZE   = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int IDX_W         = $clog2(BUFFER_SIZE);
  localparam int COUNT_W       = $clog2(BUFFER_SIZE + 1);
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 2;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(12);

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC_PAY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         entry_index;
    logic [PAYLOAD_WIDTH-1:0] payload_in;
    logic                     exec_in;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [IDX_W-1:0]         alloc_index;
    logic [PAYLOAD_WIDTH-1:0] payload_out;
    logic                     exec_out;
    logic [COUNT_W-1:0]       occupancy;
    logic                     is_empty;
    logic                     is_full;
    logic                     at_threshold;
  } result_t;

  // Sequencer to scan unit.
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_value;
    logic             step;
  } scan_ctrl_t;

  // Scan unit to sequencer: the entry under the cursor.
  typedef struct packed {
    logic [IDX_W-1:0] cursor;
    logic             valid;
    logic             exec;
    logic             last;
  } scan_stat_t;

endpackage

`default_nettype wire

>>> hdl/interrupt_entry_buffer_allocator.sv
// ----------------------------------------------------------------------------
// interrupt_entry_buffer_allocator
// Buffer of interrupt entries with lowest-free-entry allocation, clear,
// partial flush, read and write, driven by a small sequencer over a shared
// entry cursor.
// ----------------------------------------------------------------------------
// Usage. A command word is taken on cmd at a rising edge where start is high
// and busy is low. Exactly one result word per command appears on result for
// a single cycle, marked by done; the receiver has no means to hold it off,
// so it must capture the word in that cycle. busy drops in the cycle that
// shows done, so the next command may be taken in that very cycle.
// The time from acceptance to the done cycle is set by the cursor, which
// examines one entry per cycle: an allocation walks from entry zero up to
// the first free entry, or through the whole buffer when it is full; a
// partial flush walks the whole buffer; clear, write and the unused codes
// look at the addressed entry only; a read also waits for the memory, whose
// read data is registered. The block works on one command at a time and
// takes no new one while busy is high. The threshold register is written
// with cfg_we and cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce this.
// Synchronous reset empties the buffer, clears the count and sets the
// threshold to twelve; the payload memory is not cleared, since an entry is
// always written when it is allocated and only valid entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module interrupt_entry_buffer_allocator import ieba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output logic               done,
  output result_t            result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FLUSH,
    S_SINGLE,
    S_READ
  } state_t;

  state_t                   state, state_next;
  cmd_t                     cmd_q;
  logic [BUFFER_SIZE-1:0]   valid_bits, valid_next;
  logic [BUFFER_SIZE-1:0]   exec_bits, exec_next;
  logic [COUNT_W-1:0]       entry_count, count_next;
  logic [COUNT_W-1:0]       threshold;
  result_t                  res_next;
  logic                     finish;

  scan_ctrl_t               scan_ctrl;
  scan_stat_t               scan_stat;

  logic                     ram_we;
  logic [PAYLOAD_WIDTH-1:0] ram_wdata;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;
  logic                     alloc_pay;

  // The cursor serves every operation: it walks the entries for allocation
  // and flush, and simply holds the addressed entry for the single accesses.
  ieba_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (scan_ctrl),
    .valid_bits (valid_bits),
    .exec_bits  (exec_bits),
    .stat       (scan_stat)
  );

  // Payload words live in memory, addressed by the cursor for both ports.
  ieba_payload_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_stat.cursor),
    .wdata (ram_wdata),
    .raddr (scan_stat.cursor),
    .rdata (ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign alloc_pay = (cmd_q.mode == MODE_ALLOC_PAY);

  always_comb begin
    state_next           = state;
    valid_next           = valid_bits;
    exec_next            = exec_bits;
    count_next           = entry_count;
    ram_we               = 1'b0;
    ram_wdata            = cmd_q.payload_in;
    scan_ctrl            = '0;
    finish               = 1'b0;
    res_next             = '0;
    res_next.status      = STATUS_OK;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          scan_ctrl.load       = 1'b1;
          scan_ctrl.load_value = cmd.entry_index;
          case (cmd.mode) inside
            MODE_ALLOC, MODE_ALLOC_PAY: begin
              scan_ctrl.load_value = '0;
              state_next           = S_ALLOC;
            end
            MODE_FLUSH: begin
              scan_ctrl.load_value = '0;
              state_next           = S_FLUSH;
            end
            default: begin
              state_next = S_SINGLE;
            end
          endcase
        end
      end

      // Lowest free entry wins; the search stops at the first one found.
      S_ALLOC: begin
        if (!scan_stat.valid) begin
          valid_next[scan_stat.cursor] = 1'b1;
          exec_next[scan_stat.cursor]  = alloc_pay & cmd_q.exec_in;
          ram_we                       = 1'b1;
          ram_wdata                    = alloc_pay ? cmd_q.payload_in : '0;
          count_next                   = entry_count + COUNT_W'(1);
          res_next.alloc_index         = scan_stat.cursor;
          finish                       = 1'b1;
        end else if (scan_stat.last) begin
          res_next.status = STATUS_FULL;
          finish          = 1'b1;
        end else begin
          scan_ctrl.step = 1'b1;
        end
      end

      // Every valid entry with its exec flag set is dropped on the way past.
      S_FLUSH: begin
        if (scan_stat.valid && scan_stat.exec) begin
          valid_next[scan_stat.cursor] = 1'b0;
          exec_next[scan_stat.cursor]  = 1'b0;
          count_next                   = entry_count - COUNT_W'(1);
        end
        if (scan_stat.last) begin
          finish = 1'b1;
        end else begin
          scan_ctrl.step = 1'b1;
        end
      end

      S_SINGLE: begin
        finish = 1'b1;
        case (cmd_q.mode)
          MODE_CLEAR: begin
            // Clearing an entry that is already free leaves the count alone.
            if (scan_stat.valid) begin
              valid_next[scan_stat.cursor] = 1'b0;
              exec_next[scan_stat.cursor]  = 1'b0;
              count_next                   = entry_count - COUNT_W'(1);
            end
          end
          MODE_WRITE: begin
            if (scan_stat.valid) begin
              ram_we                      = 1'b1;
              exec_next[scan_stat.cursor] = cmd_q.exec_in;
            end else begin
              res_next.status = STATUS_INVALID;
            end
          end
          MODE_READ: begin
            if (scan_stat.valid) begin
              // The memory read for this entry is under way; wait for it.
              finish     = 1'b0;
              state_next = S_READ;
            end else begin
              res_next.status = STATUS_INVALID;
            end
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        res_next.payload_out = ram_rdata;
        res_next.exec_out    = scan_stat.exec;
        finish               = 1'b1;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
    end

    // Flags always describe the buffer as it stands after this command.
    res_next.occupancy    = count_next;
    res_next.is_empty     = (count_next == '0);
    res_next.is_full      = (count_next == COUNT_W'(BUFFER_SIZE));
    res_next.at_threshold = (count_next >= threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_bits  <= '0;
      exec_bits   <= '0;
      entry_count <= '0;
      threshold   <= THRESHOLD_RESET;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      valid_bits  <= valid_next;
      exec_bits   <= exec_next;
      entry_count <= count_next;
      done        <= finish;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
    end
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
    end
    if (finish) begin
      result <= res_next;
    end
  end

  // The running count must always agree with the valid bits.
  `ASSERT_CLKD(a_count_matches, clk, rst, entry_count == $countones(valid_bits), "count out of step with valid bits")
  // A result is only ever shown with the sequencer back at rest.
  `ASSERT_CLKD(a_done_idle, clk, rst, done |-> !busy, "done raised while busy")
  // Every command passes through a working state, so strobes never abut.
  `ASSERT_CLKD(a_done_single, clk, rst, done |=> !done, "done high on two cycles in a row")
  // An accepted command always occupies the sequencer in the next cycle.
  `ASSERT_CLKD(a_accept_busy, clk, rst, (start && !busy) |=> busy, "command accepted but not busy")
  // A refused allocation can only happen with every entry in use.
  `ASSERT_CLKD(a_full_status, clk, rst, (done && result.status == STATUS_FULL) |-> result.is_full, "full status with free entries")

endmodule

`default_nettype wire

>>> hdl/ieba_payload_ram.sv
// ----------------------------------------------------------------------------
// ieba_payload_ram
// Payload word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ieba_payload_ram import ieba_pkg::*; (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic [PAYLOAD_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]         raddr,
  output logic [PAYLOAD_WIDTH-1:0] rdata
);

  logic [PAYLOAD_WIDTH-1:0] mem [BUFFER_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/ieba_scan.sv
// ----------------------------------------------------------------------------
// ieba_scan
// Entry cursor shared by every operation: it is loaded with the addressed
// entry or with zero, steps one entry per cycle while step is high, and
// presents that entry's valid and exec bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ieba_scan import ieba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  scan_ctrl_t             ctrl,
  input  logic [BUFFER_SIZE-1:0] valid_bits,
  input  logic [BUFFER_SIZE-1:0] exec_bits,
  output scan_stat_t             stat
);

  logic [IDX_W-1:0] cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (ctrl.load) begin
      cursor <= ctrl.load_value;
    end else if (ctrl.step) begin
      cursor <= cursor + IDX_W'(1);
    end
  end

  always_comb begin
    stat.cursor = cursor;
    stat.valid  = valid_bits[cursor];
    stat.exec   = exec_bits[cursor];
    stat.last   = (cursor == IDX_W'(BUFFER_SIZE - 1));
  end

endmodule

`default_nettype wire
